// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Stand-alone header; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, off while reset is high
`define SSSEG_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");

// Check a property on the rising clock, reset cycles included
`define SSSEG_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: property failed");

`endif

// File: rtl/ssseg_pkg.sv
// Package for the sleep session segmenter: constants, codes, types, helpers.
// No dependencies; every other file of the block but assert_macros.svh uses it.
`timescale 1ns / 1ps

package ssseg_pkg;

   // Field widths
   localparam int SUM_BITS      = 32;
   localparam int KIND_BITS     = 4;
   localparam int RAW_BITS      = 8;
   localparam int TIME_PORT_BITS = 32;

   // Time width default and the cap set by the 32-bit timestamp port
   localparam int TIME_BITS_DEF = 32;
   localparam int TIME_BITS_CAP = 32;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_SESSION = 1'b0,
      CSR_MAX_WAKE    = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_BITS-1:0] MIN_SESSION_RESET = 32'd300;   // five minutes
   localparam logic [CSR_DATA_BITS-1:0] MAX_WAKE_RESET    = 32'd7200;  // two hours

   // Kind codes
   localparam logic [KIND_BITS-1:0] KIND_NO_CHANGE = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_LIGHT     = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_REPEAT    = 4'd10;
   localparam logic [KIND_BITS-1:0] KIND_DEEP      = 4'd11;

   // Operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // Classified word handed from front to back
   typedef struct packed {
      logic flush;
      logic light;
      logic deep;
   } class_type;

   // Saturating add of two sums
   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                   input logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

endpackage

// File: rtl/ssseg_front.sv
// Front end of the sleep session segmenter: accepts words and resolves kind codes.
// Depends on ssseg_pkg.
`timescale 1ns / 1ps

module ssseg_front #(
   parameter int TW = ssseg_pkg::TIME_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [ssseg_pkg::TIME_PORT_BITS-1:0]  req_sample_time,
   input  logic [ssseg_pkg::RAW_BITS-1:0]        req_activity,
   input  logic                                  q_full,
   output logic                                  q_push,
   output ssseg_pkg::class_type                  q_class,
   output logic [TW-1:0]                         q_time
);

   logic [ssseg_pkg::KIND_BITS-1:0] last_kind_ff, last_kind_in;
   logic [ssseg_pkg::KIND_BITS-1:0] kind;
   logic [ssseg_pkg::KIND_BITS-1:0] eff_kind;
   logic                            is_repeat;

   // Stall only when the queue has no room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Resolve repeat codes against the last real kind
   always_comb begin
      kind      = req_activity[ssseg_pkg::KIND_BITS-1:0];
      is_repeat = (kind == ssseg_pkg::KIND_NO_CHANGE) || (kind == ssseg_pkg::KIND_REPEAT);
      eff_kind  = is_repeat ? last_kind_ff : kind;
      last_kind_in = last_kind_ff;
      if (q_push && (req_op == ssseg_pkg::OP_SAMPLE) && !is_repeat) begin
         last_kind_in = kind;
      end
   end

   // Build the classified word
   always_comb begin
      q_class.flush = (req_op == ssseg_pkg::OP_FLUSH);
      q_class.light = (eff_kind == ssseg_pkg::KIND_LIGHT);
      q_class.deep  = (eff_kind == ssseg_pkg::KIND_DEEP);
      q_time        = req_sample_time[TW-1:0];
   end

   // Last real kind persists across windows
   always_ff @(posedge clock) begin
      if (reset) begin
         last_kind_ff <= '0;
      end else begin
         last_kind_ff <= last_kind_in;
      end
   end

endmodule

// File: rtl/ssseg_queue.sv
// Short queue of classified words between front and back of the segmenter.
// Depends on ssseg_pkg.
`timescale 1ns / 1ps

module ssseg_queue #(
   parameter int TW = ssseg_pkg::TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ssseg_pkg::class_type  push_class,
   input  logic [TW-1:0]         push_time,
   output logic                  full,
   output logic                  not_empty,
   input  logic                  pop,
   output ssseg_pkg::class_type  pop_class,
   output logic [TW-1:0]         pop_time
);

   localparam int DEPTH   = ssseg_pkg::QUEUE_DEPTH;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ssseg_pkg::class_type class_mem [DEPTH];
   logic [TW-1:0]        time_mem  [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign pop_class = class_mem[rd_ptr_ff];
   assign pop_time  = time_mem[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         class_mem[wr_ptr_ff] <= push_class;
         time_mem[wr_ptr_ff]  <= push_time;
      end
   end

endmodule

// File: rtl/ssseg_back.sv
// Back end of the segmenter: session state, sums, report check, result and configuration registers.
// Depends on ssseg_pkg.
`timescale 1ns / 1ps

module ssseg_back #(
   parameter int TW = ssseg_pkg::TIME_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [ssseg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ssseg_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                                 q_not_empty,
   output logic                                 q_pop,
   input  ssseg_pkg::class_type                 q_class,
   input  logic [TW-1:0]                        q_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ssseg_pkg::SUM_BITS-1:0]       rsp_session_start,
   output logic [ssseg_pkg::SUM_BITS-1:0]       rsp_session_end,
   output logic [ssseg_pkg::SUM_BITS-1:0]       rsp_light_seconds,
   output logic [ssseg_pkg::SUM_BITS-1:0]       rsp_deep_seconds
);

   localparam int SB = ssseg_pkg::SUM_BITS;

   // Configuration
   logic [SB-1:0] min_ff, max_ff;

   // Window state
   logic          open_ff, open_in;
   logic [TW-1:0] prev_ff, prev_in;
   logic [TW-1:0] start_ff, start_in;
   logic [TW-1:0] stop_ff, stop_in;
   logic [SB-1:0] light_ff, light_in;
   logic [SB-1:0] deep_ff, deep_in;
   logic [SB-1:0] wake_ff, wake_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0] rsp_start_ff, rsp_stop_ff, rsp_light_ff, rsp_deep_ff;

   logic          qualify;
   logic          report;
   logic          sleep;
   logic [TW-1:0] dur;
   logic [SB-1:0] dur_sum;
   logic [SB-1:0] wake_sum;
   logic          load;

   // Take a word whenever the result register is free or being drained
   assign q_pop = q_not_empty && (!rsp_valid_ff || !rsp_stall);
   assign load  = q_pop && report;

   // Light plus deep must exceed the minimum
   assign qualify = ({1'b0, light_ff} + {1'b0, deep_ff}) > {1'b0, min_ff};

   // Interval from the previous sample, zero when time runs backwards
   assign dur      = (q_time >= prev_ff) ? (q_time - prev_ff) : '0;
   assign dur_sum  = SB'(dur);
   assign wake_sum = ssseg_pkg::sat_add(wake_ff, dur_sum);
   assign sleep    = q_class.light || q_class.deep;

   // Update window state for the word at the head of the queue
   always_comb begin
      open_in  = open_ff;
      prev_in  = prev_ff;
      start_in = start_ff;
      stop_in  = stop_ff;
      light_in = light_ff;
      deep_in  = deep_ff;
      wake_in  = wake_ff;
      report   = 1'b0;
      if (q_pop) begin
         if (q_class.flush) begin
            report   = qualify;
            open_in  = 1'b0;
            prev_in  = '0;
            start_in = '0;
            stop_in  = '0;
            light_in = '0;
            deep_in  = '0;
            wake_in  = '0;
         end else begin
            if (sleep) begin
               if (!open_ff) begin
                  open_in  = 1'b1;
                  start_in = q_time;
               end
               stop_in = q_time;
               wake_in = '0;
            end
            if (prev_ff != '0) begin
               if (q_class.light) begin
                  light_in = ssseg_pkg::sat_add(light_ff, dur_sum);
               end else if (q_class.deep) begin
                  deep_in = ssseg_pkg::sat_add(deep_ff, dur_sum);
               end else begin
                  wake_in = wake_sum;
                  // Close the session after too much wake time
                  if (open_ff && (wake_sum > max_ff)) begin
                     report   = qualify;
                     open_in  = 1'b0;
                     start_in = '0;
                     stop_in  = '0;
                     light_in = '0;
                     deep_in  = '0;
                  end
               end
            end
            prev_in = q_time;
         end
      end
   end

   // Hold a result until taken, load a new one on a report
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         prev_ff      <= '0;
         start_ff     <= '0;
         stop_ff      <= '0;
         light_ff     <= '0;
         deep_ff      <= '0;
         wake_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         open_ff      <= open_in;
         prev_ff      <= prev_in;
         start_ff     <= start_in;
         stop_ff      <= stop_in;
         light_ff     <= light_in;
         deep_ff      <= deep_in;
         wake_ff      <= wake_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_start_ff <= SB'(start_ff);
         rsp_stop_ff  <= SB'(stop_ff);
         rsp_light_ff <= light_ff;
         rsp_deep_ff  <= deep_ff;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= ssseg_pkg::MIN_SESSION_RESET;
         max_ff <= ssseg_pkg::MAX_WAKE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ssseg_pkg::CSR_MIN_SESSION: begin
               min_ff <= csr_data;
            end
            ssseg_pkg::CSR_MAX_WAKE: begin
               max_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_session_start = rsp_start_ff;
   assign rsp_session_end   = rsp_stop_ff;
   assign rsp_light_seconds = rsp_light_ff;
   assign rsp_deep_seconds  = rsp_deep_ff;

endmodule

// File: rtl/sleep_session_segmenter.sv
// Sleep session segmenter: request channel of samples and flushes, result
// channel of reported sessions, two configuration registers.
// Channels: req_ carries op, sample_time and activity; a word is taken when
//   req_valid is high and req_stall is low. rsp_ carries one session word
//   when a closing session or a flush finds enough sleep; it is taken when
//   rsp_valid is high and rsp_stall is low.
// Configuration: csr_write with csr_index 0 (minimum session seconds) or
//   1 (maximum wake seconds) and csr_data; write only while idle.
// Throughput: one word per cycle while rsp_stall is low. The front resolves the kind
//   in the accepting cycle and pushes into a two-entry queue; the back
//   takes one queued word per cycle unless stalled, loading results on a report.
// Path: an accepted word is written into the queue; the back pops it from
//   there and, on a report, loads the result register that drives rsp_valid.
// Stall: while rsp_stall holds a result, the back stops and the queue
//   fills; req_stall rises once both queue entries are taken.
// Reset: synchronous, active high; clears all window state and the last
//   real kind, loads 300 and 7200 into the registers, empties the queue.
// Depends on ssseg_pkg, ssseg_front, ssseg_queue and ssseg_back.
`timescale 1ns / 1ps

module sleep_session_segmenter #(
   parameter int TIME_BITS = ssseg_pkg::TIME_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [ssseg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ssseg_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [ssseg_pkg::TIME_PORT_BITS-1:0] req_sample_time,
   input  logic [ssseg_pkg::RAW_BITS-1:0]       req_activity,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ssseg_pkg::SUM_BITS-1:0]       rsp_session_start,
   output logic [ssseg_pkg::SUM_BITS-1:0]       rsp_session_end,
   output logic [ssseg_pkg::SUM_BITS-1:0]       rsp_light_seconds,
   output logic [ssseg_pkg::SUM_BITS-1:0]       rsp_deep_seconds
);

   // Stored time width: timestamps wrap at TIME_BITS, capped at the 32 bits the port holds
   localparam int TW = (TIME_BITS < ssseg_pkg::TIME_BITS_CAP) ? TIME_BITS
                                                            : ssseg_pkg::TIME_BITS_CAP;

   logic                 q_full;
   logic                 q_push;
   logic                 q_not_empty;
   logic                 q_pop;
   ssseg_pkg::class_type push_class;
   ssseg_pkg::class_type pop_class;
   logic [TW-1:0]        push_time;
   logic [TW-1:0]        pop_time;

   ssseg_front #(.TW(TW)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_sample_time (req_sample_time),
      .req_activity    (req_activity),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_class         (push_class),
      .q_time          (push_time)
   );

   ssseg_queue #(.TW(TW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_class (push_class),
      .push_time  (push_time),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .pop        (q_pop),
      .pop_class  (pop_class),
      .pop_time   (pop_time)
   );

   ssseg_back #(.TW(TW)) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .q_not_empty       (q_not_empty),
      .q_pop             (q_pop),
      .q_class           (pop_class),
      .q_time            (pop_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_session_start (rsp_session_start),
      .rsp_session_end   (rsp_session_end),
      .rsp_light_seconds (rsp_light_seconds),
      .rsp_deep_seconds  (rsp_deep_seconds)
   );

endmodule

// File: rtl/ssseg_checker.sv
// Port-level checks for the sleep session segmenter, bound to its top level.
// Depends on assert_macros.svh and ssseg_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssseg_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [ssseg_pkg::SUM_BITS-1:0] rsp_session_start,
   input logic [ssseg_pkg::SUM_BITS-1:0] rsp_session_end,
   input logic [ssseg_pkg::SUM_BITS-1:0] rsp_light_seconds,
   input logic [ssseg_pkg::SUM_BITS-1:0] rsp_deep_seconds
);

   logic [4*ssseg_pkg::SUM_BITS-1:0] rsp_word;

   // Gather the result payload into one word
   assign rsp_word = {rsp_session_start, rsp_session_end, rsp_light_seconds, rsp_deep_seconds};

   // A stalled result stays offered
   `SSSEG_ASSERT(rsp_hold_a, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // A stalled result keeps its payload
   `SSSEG_ASSERT(rsp_stable_a, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_word))

   // Reset drops any pending result
   `SSSEG_ASSERT_ALWAYS(rst_rsp_a, clock, reset |=> !rsp_valid)

   // Reset leaves the queue empty, so requests are not stalled
   `SSSEG_ASSERT_ALWAYS(rst_req_a, clock, reset |=> !req_stall)

endmodule

bind sleep_session_segmenter ssseg_checker u_checker (.*);

// File: tb/sv/sleep_session_segmenter_tb.sv
// Self-checking bench for sleep_session_segmenter: a session tracker class predicts
// reported sessions from each accepted request word and checks each response word.
// Depends on ssseg_pkg and the sleep_session_segmenter RTL.
`timescale 1ns / 1ps

module sleep_session_segmenter_tb;

   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_LIMIT   = 5000;
   localparam logic [ssseg_pkg::KIND_BITS-1:0] KIND_WALK = 4'd3;
   localparam logic [ssseg_pkg::KIND_BITS-1:0] KIND_AWAKE = 4'd5;

   typedef struct packed {
      logic [ssseg_pkg::SUM_BITS-1:0] first_t;
      logic [ssseg_pkg::SUM_BITS-1:0] last_t;
      logic [ssseg_pkg::SUM_BITS-1:0] light;
      logic [ssseg_pkg::SUM_BITS-1:0] deep;
   } session_rec_type;

   // Track window state and queue the sessions the block must report
   class session_tracker_type;
      logic [31:0]                     min_sleep;
      logic [31:0]                     max_wake;
      logic [ssseg_pkg::KIND_BITS-1:0] held_kind;
      logic [31:0]                     prev_t;
      logic                            in_session;
      logic [31:0]                     first_t;
      logic [31:0]                     last_t;
      logic [31:0]                     light_sum;
      logic [31:0]                     deep_sum;
      logic [31:0]                     wake_sum;
      session_rec_type                 pending_sessions[$];
      int unsigned                     errors;

      function new();
         min_sleep = ssseg_pkg::MIN_SESSION_RESET;
         max_wake  = ssseg_pkg::MAX_WAKE_RESET;
         held_kind = ssseg_pkg::KIND_NO_CHANGE;
         errors    = 0;
         clear_window();
      endfunction

      function void clear_window();
         prev_t     = '0;
         in_session = 1'b0;
         first_t    = '0;
         last_t     = '0;
         light_sum  = '0;
         deep_sum   = '0;
         wake_sum   = '0;
      endfunction

      function void set_reg(ssseg_pkg::csr_index_type idx, logic [31:0] val);
         case (idx)
            ssseg_pkg::CSR_MIN_SESSION: min_sleep = val;
            ssseg_pkg::CSR_MAX_WAKE:    max_wake  = val;
            default: ;
         endcase
      endfunction

      // Clamp at all ones instead of wrapping
      function logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
         if (a > 32'hFFFF_FFFF - b) return 32'hFFFF_FFFF;
         return a + b;
      endfunction

      function void offer_report();
         session_rec_type rec;
         if ({1'b0, light_sum} + {1'b0, deep_sum} > {1'b0, min_sleep}) begin
            rec.first_t = first_t;
            rec.last_t  = last_t;
            rec.light   = light_sum;
            rec.deep    = deep_sum;
            pending_sessions.push_back(rec);
         end
      endfunction

      // Advance the window by one accepted request word
      function void note_word(logic op, logic [31:0] t, logic [ssseg_pkg::RAW_BITS-1:0] raw);
         logic [ssseg_pkg::KIND_BITS-1:0] kind;
         logic [31:0]                     span;
         if (op == ssseg_pkg::OP_FLUSH) begin
            offer_report();
            clear_window();
            return;
         end
         kind = raw[ssseg_pkg::KIND_BITS-1:0];
         if (kind == ssseg_pkg::KIND_NO_CHANGE || kind == ssseg_pkg::KIND_REPEAT) begin
            kind = held_kind;
         end else begin
            held_kind = kind;
         end
         if (kind == ssseg_pkg::KIND_LIGHT || kind == ssseg_pkg::KIND_DEEP) begin
            if (!in_session) begin
               in_session = 1'b1;
               first_t    = t;
            end
            last_t   = t;
            wake_sum = '0;
         end
         if (prev_t != 0) begin
            span = (t >= prev_t) ? t - prev_t : '0;
            if (kind == ssseg_pkg::KIND_LIGHT) begin
               light_sum = add_clamped(light_sum, span);
            end else if (kind == ssseg_pkg::KIND_DEEP) begin
               deep_sum = add_clamped(deep_sum, span);
            end else begin
               wake_sum = add_clamped(wake_sum, span);
               // Close the session once wake time runs past the limit
               if (in_session && wake_sum > max_wake) begin
                  offer_report();
                  in_session = 1'b0;
                  first_t    = '0;
                  last_t     = '0;
                  light_sum  = '0;
                  deep_sum   = '0;
               end
            end
         end
         prev_t = t;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      // Match a response word against the oldest pending session
      function void check_session(session_rec_type got);
         session_rec_type want;
         if (pending_sessions.size() == 0) begin
            $display("%0t: unexpected session word, expected none actual %h %h %h %h",
                     $time, got.first_t, got.last_t, got.light, got.deep);
            errors++;
            return;
         end
         want = pending_sessions.pop_front();
         compare_field("session_start", want.first_t, got.first_t);
         compare_field("session_end", want.last_t, got.last_t);
         compare_field("light_seconds", want.light, got.light);
         compare_field("deep_seconds", want.deep, got.deep);
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_write;
   logic [ssseg_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [ssseg_pkg::CSR_DATA_BITS-1:0]  csr_data;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_op;
   logic [ssseg_pkg::TIME_PORT_BITS-1:0] req_sample_time;
   logic [ssseg_pkg::RAW_BITS-1:0]       req_activity;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [ssseg_pkg::SUM_BITS-1:0]       rsp_session_start;
   logic [ssseg_pkg::SUM_BITS-1:0]       rsp_session_end;
   logic [ssseg_pkg::SUM_BITS-1:0]       rsp_light_seconds;
   logic [ssseg_pkg::SUM_BITS-1:0]       rsp_deep_seconds;

   session_tracker_type sb = new();
   logic                calm = 1'b0;
   logic                hold_request = 1'b0;
   int                  idle_cycles = 0;

   sleep_session_segmenter DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_sample_time   (req_sample_time),
      .req_activity      (req_activity),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_session_start (rsp_session_start),
      .rsp_session_end   (rsp_session_end),
      .rsp_light_seconds (rsp_light_seconds),
      .rsp_deep_seconds  (rsp_deep_seconds)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one request word, hold it until taken, then maybe idle a burst
   task automatic send_word(input logic op, input logic [31:0] t,
                            input logic [ssseg_pkg::RAW_BITS-1:0] raw);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_sample_time <= t;
      req_activity    <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(op, t, raw);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Stop offering and let every pending session come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_sessions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the minimum register, then the wake register; block must be idle
   task automatic write_regs(input logic [31:0] min_val, input logic [31:0] wake_val);
      csr_write <= 1'b1;
      csr_index <= ssseg_pkg::CSR_MIN_SESSION;
      csr_data  <= min_val;
      @(posedge clock);
      csr_index <= ssseg_pkg::CSR_MAX_WAKE;
      csr_data  <= wake_val;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_reg(ssseg_pkg::CSR_MIN_SESSION, min_val);
      sb.set_reg(ssseg_pkg::CSR_MAX_WAKE, wake_val);
   endtask

   // Mostly runs of sleep or wake samples with rising times, plus flushes and noise
   task automatic run_phase(input int count, input int unsigned step_max);
      logic [31:0]                     now;
      int                              run_left;
      logic                            sleepy;
      logic [ssseg_pkg::KIND_BITS-1:0] code;
      int unsigned                     pick;
      now      = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 1000);
      run_left = 0;
      sleepy   = 1'b0;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_word(ssseg_pkg::OP_FLUSH, $urandom, 8'($urandom));
         end else if (pick < 10) begin
            send_word(ssseg_pkg::OP_SAMPLE, $urandom, 8'($urandom));
         end else begin
            if (run_left == 0) begin
               sleepy   = 1'($urandom_range(0, 1));
               run_left = $urandom_range(1, 8);
            end
            run_left--;
            now = now + $urandom_range(0, step_max);
            if ($urandom_range(0, 3) == 0) begin
               code = $urandom_range(0, 1) ? ssseg_pkg::KIND_NO_CHANGE : ssseg_pkg::KIND_REPEAT;
            end else if (sleepy) begin
               code = $urandom_range(0, 1) ? ssseg_pkg::KIND_LIGHT : ssseg_pkg::KIND_DEEP;
            end else begin
               do code = 4'($urandom_range(1, 15));
               while (code == ssseg_pkg::KIND_LIGHT || code == ssseg_pkg::KIND_REPEAT ||
                      code == ssseg_pkg::KIND_DEEP);
            end
            send_word(ssseg_pkg::OP_SAMPLE, (pick < 12) ? 32'd0 : now,
                      {4'($urandom_range(0, 15)), code});
         end
      end
   endtask

   // Receiver: random stall bursts, a long hold on request, none when calm
   initial begin
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Check every response word taken
   always @(posedge clock) begin : rsp_monitor
      session_rec_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.first_t = rsp_session_start;
         got.last_t  = rsp_session_end;
         got.light   = rsp_light_seconds;
         got.deep    = rsp_deep_seconds;
         sb.check_session(got);
      end
   end

   // Watchdog: give up after a long stretch with no word moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("sleep_session_segmenter verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] now;
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = ssseg_pkg::CSR_MIN_SESSION;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_op          = ssseg_pkg::OP_SAMPLE;
      req_sample_time = '0;
      req_activity    = '0;
      rsp_stall       = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under reset register values
      // repeat before any real kind
      send_word(ssseg_pkg::OP_SAMPLE, 32'd100, {4'h0, ssseg_pkg::KIND_NO_CHANGE});
      // zero timestamp
      send_word(ssseg_pkg::OP_SAMPLE, 32'd0, {4'h0, ssseg_pkg::KIND_REPEAT});
      // no interval after zero time
      send_word(ssseg_pkg::OP_SAMPLE, 32'd50, {4'h0, ssseg_pkg::KIND_LIGHT});
      // time going backwards
      send_word(ssseg_pkg::OP_SAMPLE, 32'd40, {4'hF, ssseg_pkg::KIND_LIGHT});
      send_word(ssseg_pkg::OP_SAMPLE, 32'd400, {4'h0, ssseg_pkg::KIND_DEEP});
      send_word(ssseg_pkg::OP_SAMPLE, 32'd500, {4'h0, ssseg_pkg::KIND_REPEAT});
      send_word(ssseg_pkg::OP_SAMPLE, 32'd600, {4'h0, KIND_WALK});
      // wake limit closes session
      send_word(ssseg_pkg::OP_SAMPLE, 32'd8000, {4'h0, KIND_AWAKE});
      // wake total kept after close
      send_word(ssseg_pkg::OP_SAMPLE, 32'd8100, {4'h0, ssseg_pkg::KIND_NO_CHANGE});
      // flush with too little sleep
      send_word(ssseg_pkg::OP_FLUSH, 32'hFFFF_FFFF, 8'hFF);
      // Saturate the light sum, then flush it out
      send_word(ssseg_pkg::OP_SAMPLE, 32'd1, {4'h0, ssseg_pkg::KIND_LIGHT});
      send_word(ssseg_pkg::OP_SAMPLE, 32'hFFFF_FFFF, {4'h0, ssseg_pkg::KIND_LIGHT});
      send_word(ssseg_pkg::OP_SAMPLE, 32'd1, {4'h0, ssseg_pkg::KIND_LIGHT});
      send_word(ssseg_pkg::OP_SAMPLE, 32'hFFFF_FFFF, {4'h1, ssseg_pkg::KIND_LIGHT});
      send_word(ssseg_pkg::OP_FLUSH, 32'd0, 8'h00);
      // Saturate the deep sum, partly through repeat codes
      send_word(ssseg_pkg::OP_SAMPLE, 32'd1, {4'h5, ssseg_pkg::KIND_DEEP});
      send_word(ssseg_pkg::OP_SAMPLE, 32'hFFFF_FFFF, {4'hA, ssseg_pkg::KIND_REPEAT});
      send_word(ssseg_pkg::OP_SAMPLE, 32'd1, {4'h0, ssseg_pkg::KIND_NO_CHANGE});
      send_word(ssseg_pkg::OP_SAMPLE, 32'hFFFF_FFFF, {4'h0, ssseg_pkg::KIND_DEEP});
      send_word(ssseg_pkg::OP_FLUSH, 32'h8000_0000, 8'hA5);

      wait_drained();
      write_regs(32'd0, 32'd0);
      run_phase(100, 50);

      // Hold the receiver off while sessions keep closing, so the input stalls
      wait_drained();
      hold_request = 1'b1;
      now = 32'd1000;
      for (int i = 0; i < 30; i++) begin
         send_word(ssseg_pkg::OP_SAMPLE, now, {4'h0, ssseg_pkg::KIND_LIGHT});
         send_word(ssseg_pkg::OP_SAMPLE, now + 32'd5, {4'h0, ssseg_pkg::KIND_LIGHT});
         send_word(ssseg_pkg::OP_SAMPLE, now + 32'd10, {4'h0, KIND_WALK});
         now = now + 32'd20;
      end

      wait_drained();
      write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_phase(80, 32'h7FFF_FFFF);

      wait_drained();
      write_regs(32'd100, 32'd500);
      run_phase(110, 200);

      wait_drained();
      write_regs($urandom_range(0, 5000), $urandom_range(0, 20000));
      run_phase(100, 1500);

      // Last part runs with no idling on either side
      wait_drained();
      calm = 1'b1;
      write_regs(32'd1000, 32'd3000);
      run_phase(120, 600);

      wait_drained();
      if (sb.errors == 0) begin
         $display("sleep_session_segmenter verification clean");
      end else begin
         $display("sleep_session_segmenter verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ssseg_pkg.sv
rtl/ssseg_front.sv
rtl/ssseg_queue.sv
rtl/ssseg_back.sv
rtl/sleep_session_segmenter.sv
rtl/ssseg_checker.sv
tb/sv/sleep_session_segmenter_tb.sv
